[hdl/fnrp_pkg.sv]
// shared types and constants for the binary64 normalise, round and pack block
// no dependencies; imported by every module of the block
`default_nettype none

package fnrp_pkg;

  localparam int unsigned MantW  = 56;
  localparam int unsigned ExpW   = 64;
  localparam int unsigned FracW  = 52;
  localparam int unsigned ShiftW = 6;

  // exponent limits, taken as signed 64-bit values
  localparam logic signed [ExpW-1:0] ExpAllOnes   = 64'sh7FF;
  localparam logic signed [ExpW-1:0] ExpMaxFinite = 64'sh7FE;
  localparam logic signed [ExpW-1:0] FlushShift   = 64'sd56;

  // sticky-free round point: guard bit set, round and sticky clear
  localparam logic [2:0] GrsHalf = 3'b100;

  typedef struct packed {
    logic [MantW-1:0]       working_mantissa;
    logic signed [ExpW-1:0] exponent_in;
    logic                   sign_in;
  } in_t;

  typedef struct packed {
    logic [63:0] packed_word;
    logic [63:0] infinity_word;
    logic [63:0] zero_word;
    logic        exponent_overflow;
    logic        overflow_after_round;
    logic        was_subnormal;
    logic        flushed_to_zero;
  } out_t;

  // normalised operand passed from the leading-zero ladder to rounding
  typedef struct packed {
    logic [MantW-1:0]       mant;
    logic signed [ExpW-1:0] exp;
    logic                   sign;
  } norm_t;

endpackage

`default_nettype wire

[hdl/fp64_normalize_round_pack.sv]
// binary64 normalise, round to nearest even and pack, top level
// the input register holds the accepted request; the result register loads from it once it is free
// throughput: one request per cycle while the output is not stalled; an empty input register fills while a result waits
// the critical path is the ladder, 64-bit exponent adjust, subnormal shift and round carry
// reset: asynchronous active-low, clears both valid flags; payload registers are not reset
// depends on fnrp_pkg, fnrp_normalize and fnrp_round
`default_nettype none

module fp64_normalize_round_pack (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  fnrp_pkg::in_t  in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output fnrp_pkg::out_t out_req_o
);
  import fnrp_pkg::*;

  logic  s1_valid_q, s1_valid_d;
  in_t   s1_req_q;
  logic  out_valid_q, out_valid_d;
  out_t  out_req_q;
  logic  advance, in_fire;
  norm_t norm;
  out_t  res;

  // handshake: the result register frees when empty or taken
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d  = in_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
    out_valid_d = advance ? s1_valid_q : out_valid_q;
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_req_q <= in_req_i;
    end
    if (advance && s1_valid_q) begin
      out_req_q <= res;
    end
  end

  fnrp_normalize u_normalize (
    .req_i  (s1_req_q),
    .norm_o (norm)
  );

  fnrp_round u_round (
    .norm_i (norm),
    .res_o  (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule

`default_nettype wire

[hdl/fnrp_normalize.sv]
// leading-zero ladder: moves the leading one to bit 55 and lowers the exponent
// depends on fnrp_pkg
`default_nettype none

module fnrp_normalize (
  input  fnrp_pkg::in_t   req_i,
  output fnrp_pkg::norm_t norm_o
);
  import fnrp_pkg::*;

  logic [MantW-1:0]  m0, m1, m2, m3, m4, m5, m6;
  logic [ShiftW-1:0] lz;

  // six ladder stages, each shifts when its top window is empty
  always_comb begin
    m0    = req_i.working_mantissa;
    lz[5] = (m0[55:24] == '0);
    m1    = lz[5] ? {m0[23:0], 32'd0} : m0;
    lz[4] = (m1[55:40] == '0);
    m2    = lz[4] ? {m1[39:0], 16'd0} : m1;
    lz[3] = (m2[55:48] == '0);
    m3    = lz[3] ? {m2[47:0], 8'd0} : m2;
    lz[2] = (m3[55:52] == '0);
    m4    = lz[2] ? {m3[51:0], 4'd0} : m3;
    lz[1] = (m4[55:54] == '0);
    m5    = lz[1] ? {m4[53:0], 2'd0} : m4;
    lz[0] = ~m5[55];
    m6    = lz[0] ? {m5[54:0], 1'b0} : m5;
  end

  // exponent drops by the total shift, wrapping mod 2^64
  assign norm_o.mant = m6;
  assign norm_o.exp  = req_i.exponent_in - $signed({{(ExpW-ShiftW){1'b0}}, lz});
  assign norm_o.sign = req_i.sign_in;

endmodule

`default_nettype wire

[hdl/fnrp_round.sv]
// subnormal denormalisation, round to nearest even and binary64 packing
// depends on fnrp_pkg
`default_nettype none

module fnrp_round (
  input  fnrp_pkg::norm_t norm_i,
  output fnrp_pkg::out_t  res_o
);
  import fnrp_pkg::*;

  logic signed [ExpW-1:0] shift, e2, e_after;
  logic [ShiftW-1:0]      shift_c;
  logic [MantW-1:0]       drop_mask, m_sub, m2;
  logic                   subn, ftz, sticky, rnd_up, carry;
  logic [FracW-1:0]       frac, frac_fin;
  logic [FracW:0]         frac_inc;
  logic [2:0]             grs;
  logic [10:0]            e_pack;

  // subnormal step: right shift by 1 - exponent with sticky folding
  always_comb begin
    subn  = norm_i.exp[ExpW-1] | (norm_i.exp == '0);
    shift = 64'sd1 - norm_i.exp;
    ftz   = (shift >= FlushShift);
    if (ftz || shift[ExpW-1]) begin
      shift_c = '0;
    end else begin
      shift_c = shift[ShiftW-1:0];
    end
    drop_mask = (MantW'(1) << shift_c) - MantW'(1);
    sticky    = |(norm_i.mant & drop_mask);
    m_sub     = (norm_i.mant >> shift_c) | MantW'(sticky);
    m2        = (subn && !ftz) ? m_sub : norm_i.mant;
    e2        = subn ? '0 : norm_i.exp;
  end

  // round to nearest, ties to even, with carry into the exponent
  always_comb begin
    frac     = m2[FracW+2:3];
    grs      = m2[2:0];
    rnd_up   = (grs > GrsHalf) || ((grs == GrsHalf) && frac[0]);
    frac_inc = {1'b0, frac} + (FracW+1)'(1);
    carry    = frac_inc[FracW];
    frac_fin = rnd_up ? frac_inc[FracW-1:0] : frac;
    e_after  = e2 + $signed({{(ExpW-1){1'b0}}, rnd_up & carry});
  end

  // exponent clamp to the finite range
  always_comb begin
    priority if (e_after[ExpW-1]) begin
      e_pack = '0;
    end else if (e_after > ExpMaxFinite) begin
      e_pack = ExpMaxFinite[10:0];
    end else begin
      e_pack = e_after[10:0];
    end
  end

  assign res_o.packed_word          = {norm_i.sign, e_pack, frac_fin};
  assign res_o.infinity_word        = {norm_i.sign, ExpAllOnes[10:0], {FracW{1'b0}}};
  assign res_o.zero_word            = {norm_i.sign, 63'd0};
  assign res_o.exponent_overflow    = (e2 >= ExpAllOnes);
  assign res_o.overflow_after_round = (e_after >= ExpAllOnes);
  assign res_o.was_subnormal        = subn;
  assign res_o.flushed_to_zero      = ftz;

endmodule

`default_nettype wire

[hdl/fnrp_checker.sv]
// port-level checks for the binary64 normalise, round and pack block
// depends on fnrp_pkg; bound to fp64_normalize_round_pack below
`default_nettype none

module fnrp_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_o,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire fnrp_pkg::out_t out_req_o
);
  import fnrp_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // infinity and zero words carry the same sign as the packed word, with their fixed exponent and fraction bits
  a_sign_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.infinity_word[63] == out_req_o.packed_word[63])
                 && (out_req_o.zero_word[63] == out_req_o.packed_word[63])
                 && (out_req_o.infinity_word[62:0] == {ExpAllOnes[10:0], 52'd0})
                 && (out_req_o.zero_word[62:0] == 63'd0))
    else $error("special words inconsistent with result sign");

  // flush to zero only arises from a subnormal exponent
  a_flush_subn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.flushed_to_zero |-> out_req_o.was_subnormal)
    else $error("flush marked without subnormal exponent");

  // a subnormal result cannot report pre-round overflow
  a_subn_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.was_subnormal |-> !out_req_o.exponent_overflow)
    else $error("overflow flagged on subnormal result");

  // an empty block with a free output must take a request
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && out_ready_i && $past(!in_valid_i) && $past(rst_ni) |-> in_ready_o)
    else $error("request refused while idle");

endmodule

bind fp64_normalize_round_pack fnrp_checker u_fnrp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_req_o   (out_req_o)
);

`default_nettype wire
